>>> sv/prt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the pending request table.
// No dependencies; used by prt_ctrl, prt_dp and pending_request_table_core.
package prt_pkg;

	localparam int unsigned ENTRIES_DEF = 64;
	localparam int unsigned KEYS_DEF    = 32;

	localparam int unsigned IN_BITS  = 176;
	localparam int unsigned OUT_BITS = 104;

	typedef enum logic [2:0] {
		OP_CREATE     = 3'd0,
		OP_TICK       = 3'd1,
		OP_REMOVE     = 3'd2,
		OP_HAS_NONCE  = 3'd3,
		OP_IS_CONS    = 3'd4,
		OP_SERVED_Q   = 3'd5,
		OP_SET_SERVED = 3'd6
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// request beat, last field in the lowest bits
	typedef struct packed {
		logic        consumer;
		logic        served;
		logic [31:0] nonce;
		logic [7:0]  kind;
		logic [15:0] life;
		logic [47:0] mac;
		logic [31:0] rid;
		logic [31:0] key;
		logic [2:0]  op;
	} req_t;

	// result beat, last field in the lowest bits
	typedef struct packed {
		logic [6:0]  removed;
		logic        consumer;
		logic        served;
		logic [7:0]  kind;
		logic [47:0] mac;
		logic [31:0] rid;
		logic        answer;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] rid;
		logic [47:0] mac;
		logic [7:0]  kind;
		logic [31:0] nonce;
		logic        served;
		logic        consumer;
	} erec_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] dl;
	} trec_t;

	// controller to datapath
	typedef struct packed {
		logic escan;
		logic tscan;
		logic wr;
		logic load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic escan_done;
		logic tscan_done;
		logic dup;
		logic efree;
		logic tok;
		logic out_busy;
	} sts_t;

endpackage

>>> sv/prt_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer of the pending request table.
// Depends on prt_pkg; drives prt_dp through cmd_t and watches sts_t.
module prt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [2:0]        in_op,
	input  prt_pkg::sts_t     sts,
	output logic              in_ready,
	output prt_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ESCAN = 5'b00010,
		S_TSCAN = 5'b00100,
		S_WRITE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t      state_q, state_d;
	logic [2:0]  op_q;

	assign in_ready = (state_q == S_IDLE);

	// state register; latch the request code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= 3'd0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				op_q <= in_op;
			end
		end
	end

	// next state, sweep starts, write and result load
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (in_op)
						prt_pkg::OP_CREATE, prt_pkg::OP_HAS_NONCE, prt_pkg::OP_IS_CONS,
						prt_pkg::OP_SERVED_Q, prt_pkg::OP_SET_SERVED: begin
							state_d   = S_ESCAN;
							cmd.escan = 1'b1;
						end
						prt_pkg::OP_TICK, prt_pkg::OP_REMOVE: begin
							state_d   = S_TSCAN;
							cmd.tscan = 1'b1;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_ESCAN: begin
				if (sts.escan_done) begin
					if (op_q == prt_pkg::OP_CREATE && !sts.dup && sts.efree) begin
						state_d   = S_TSCAN;
						cmd.tscan = 1'b1;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_TSCAN: begin
				if (sts.tscan_done) begin
					if (op_q == prt_pkg::OP_CREATE) begin
						state_d = sts.tok ? S_WRITE : S_DONE;
					end else begin
						state_d   = S_ESCAN;
						cmd.escan = 1'b1;
					end
				end
			end
			S_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> sv/prt_dp.sv
`timescale 1ns / 1ps
// Datapath of the pending request table: entry and deadline memories, sweeps, result register.
// Depends on prt_pkg; sequenced by prt_ctrl.
module prt_dp #(
	parameter int unsigned ENTRIES = prt_pkg::ENTRIES_DEF,
	parameter int unsigned KEYS    = prt_pkg::KEYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_fire,
	input  logic [prt_pkg::IN_BITS-1:0]   in_data,
	input  prt_pkg::cmd_t                 cmd,
	output prt_pkg::sts_t                 sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prt_pkg::OUT_BITS-1:0]  out_data
);

	localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned KW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam logic [EW-1:0] ELAST = EW'(ENTRIES - 1);
	localparam logic [KW-1:0] KLAST = KW'(KEYS - 1);

	prt_pkg::req_t  req_q;
	prt_pkg::erec_t emem [ENTRIES];
	logic [EW-1:0]  omem [ENTRIES];
	logic [KW-1:0]  imem [ENTRIES];
	prt_pkg::trec_t tmem [KEYS];
	logic [ENTRIES-1:0] evalid_q;
	logic [KEYS-1:0]    tvalid_q, exp_q;
	logic [31:0]        now_q;

	logic           esweep_q, evld_s1;
	logic [EW-1:0]  ecnt_q, eidx_s1;
	prt_pkg::erec_t erec_s1;
	logic [EW-1:0]  eord_s1;
	logic [KW-1:0]  etid_s1;
	logic           tsweep_q, tvld_s1;
	logic [KW-1:0]  tcnt_q, tidx_s1;
	prt_pkg::trec_t trec_s1;
	logic           escan_done_q, tscan_done_q;

	logic           dup_q, efree_q, tmatch_q, tfree_q, ans_q;
	logic [EW-1:0]  dup_ord_q, free_idx_q;
	prt_pkg::erec_t dup_rec_q;
	logic [EW:0]    rank_q;
	logic [KW-1:0]  tslot_q, tfree_idx_q;
	logic [6:0]     rem_q;
	prt_pkg::res_t  out_q, res;
	logic           out_valid_q;

	logic           ev, km, nm, tv, tkm, texp, set_srv;
	prt_pkg::erec_t srv_rec, new_rec;
	logic [KW-1:0]  wslot;

	// decode of the word in the sweep stage
	assign ev      = evld_s1 && evalid_q[eidx_s1];
	assign km      = ev && (erec_s1.key == req_q.key);
	assign nm      = erec_s1.nonce == req_q.nonce;
	assign tv      = tvld_s1 && tvalid_q[tidx_s1];
	assign tkm     = tv && (trec_s1.key == req_q.key);
	assign texp    = tv && !(now_q - trec_s1.dl >= 32'h8000_0000);
	assign set_srv = km && (req_q.op == prt_pkg::OP_SET_SERVED);
	assign wslot   = tmatch_q ? tslot_q : tfree_idx_q;

	always_comb begin
		srv_rec          = erec_s1;
		srv_rec.served   = 1'b1;
		new_rec.key      = req_q.key;
		new_rec.rid      = req_q.rid;
		new_rec.mac      = req_q.mac;
		new_rec.kind     = req_q.kind;
		new_rec.nonce    = req_q.nonce;
		new_rec.served   = req_q.served;
		new_rec.consumer = req_q.consumer;
	end

	// hold the request, advance time on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= 32'd0;
		end else if (in_fire && in_data[2:0] == prt_pkg::OP_TICK) begin
			now_q <= now_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= prt_pkg::req_t'(in_data[$bits(prt_pkg::req_t)-1:0]);
		end
	end

	// sweep address counters; done is flagged once the last word has been folded in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esweep_q     <= 1'b0;
			ecnt_q       <= '0;
			evld_s1      <= 1'b0;
			eidx_s1      <= '0;
			tsweep_q     <= 1'b0;
			tcnt_q       <= '0;
			tvld_s1      <= 1'b0;
			tidx_s1      <= '0;
			escan_done_q <= 1'b0;
			tscan_done_q <= 1'b0;
		end else begin
			evld_s1      <= esweep_q;
			eidx_s1      <= ecnt_q;
			tvld_s1      <= tsweep_q;
			tidx_s1      <= tcnt_q;
			escan_done_q <= evld_s1 && (eidx_s1 == ELAST);
			tscan_done_q <= tvld_s1 && (tidx_s1 == KLAST);
			if (cmd.escan) begin
				esweep_q <= 1'b1;
				ecnt_q   <= '0;
			end else if (esweep_q) begin
				if (ecnt_q == ELAST) begin
					esweep_q <= 1'b0;
				end else begin
					ecnt_q <= ecnt_q + EW'(1);
				end
			end
			if (cmd.tscan) begin
				tsweep_q <= 1'b1;
				tcnt_q   <= '0;
			end else if (tsweep_q) begin
				if (tcnt_q == KLAST) begin
					tsweep_q <= 1'b0;
				end else begin
					tcnt_q <= tcnt_q + KW'(1);
				end
			end
		end
	end

	assign sts.escan_done = escan_done_q;
	assign sts.tscan_done = tscan_done_q;

	// entry memory: registered read, one write port
	always_ff @(posedge clk) begin
		if (esweep_q) begin
			erec_s1 <= emem[ecnt_q];
			eord_s1 <= omem[ecnt_q];
			etid_s1 <= imem[ecnt_q];
		end
		if (cmd.wr) begin
			emem[free_idx_q] <= new_rec;
			omem[free_idx_q] <= rank_q[EW-1:0];
			imem[free_idx_q] <= wslot;
		end else if (set_srv) begin
			emem[eidx_s1] <= srv_rec;
		end
	end

	// deadline memory
	always_ff @(posedge clk) begin
		if (tsweep_q) begin
			trec_s1 <= tmem[tcnt_q];
		end
		if (cmd.wr) begin
			tmem[wslot] <= '{key: req_q.key, dl: now_q + {16'd0, req_q.life}};
		end
	end

	// valid bits and expiry marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evalid_q <= '0;
			tvalid_q <= '0;
			exp_q    <= '0;
		end else begin
			if (in_fire) begin
				exp_q <= '0;
			end
			if (cmd.wr) begin
				evalid_q[free_idx_q] <= 1'b1;
				tvalid_q[wslot]      <= 1'b1;
			end
			if (ev && (req_q.op == prt_pkg::OP_TICK || req_q.op == prt_pkg::OP_REMOVE)
				&& exp_q[etid_s1]) begin
				evalid_q[eidx_s1] <= 1'b0;
			end
			if ((req_q.op == prt_pkg::OP_TICK && texp)
				|| (req_q.op == prt_pkg::OP_REMOVE && tkm)) begin
				exp_q[tidx_s1]    <= 1'b1;
				tvalid_q[tidx_s1] <= 1'b0;
			end
		end
	end

	// per-request scan results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q    <= 1'b0;
			efree_q  <= 1'b0;
			tmatch_q <= 1'b0;
			tfree_q  <= 1'b0;
			ans_q    <= 1'b0;
			rank_q   <= '0;
			rem_q    <= '0;
		end else if (in_fire) begin
			dup_q    <= 1'b0;
			efree_q  <= 1'b0;
			tmatch_q <= 1'b0;
			tfree_q  <= 1'b0;
			ans_q    <= 1'b0;
			rank_q   <= '0;
			rem_q    <= '0;
		end else begin
			case (req_q.op)
				prt_pkg::OP_CREATE: begin
					if (km) begin
						rank_q <= rank_q + (EW+1)'(1);
						if (nm && (!dup_q || eord_s1 < dup_ord_q)) begin
							dup_q <= 1'b1;
						end
					end
					if (evld_s1 && !evalid_q[eidx_s1] && !efree_q) begin
						efree_q <= 1'b1;
					end
					if (tkm) begin
						tmatch_q <= 1'b1;
					end
					if (tvld_s1 && !tvalid_q[tidx_s1] && !tfree_q) begin
						tfree_q <= 1'b1;
					end
				end
				prt_pkg::OP_TICK, prt_pkg::OP_REMOVE: begin
					if (ev && exp_q[etid_s1] && rem_q != 7'h7f) begin
						rem_q <= rem_q + 7'd1;
					end
				end
				prt_pkg::OP_HAS_NONCE: begin
					if (km && nm && eord_s1 == '0) begin
						ans_q <= 1'b1;
					end
				end
				prt_pkg::OP_IS_CONS: begin
					if (km && erec_s1.consumer) begin
						ans_q <= 1'b1;
					end
				end
				prt_pkg::OP_SERVED_Q: begin
					if (km && nm && erec_s1.served) begin
						ans_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload captured beside the scan flags
	always_ff @(posedge clk) begin
		if (req_q.op == prt_pkg::OP_CREATE && km && nm && (!dup_q || eord_s1 < dup_ord_q)) begin
			dup_ord_q <= eord_s1;
			dup_rec_q <= erec_s1;
		end
		if (evld_s1 && !evalid_q[eidx_s1] && !efree_q) begin
			free_idx_q <= eidx_s1;
		end
		if (tkm) begin
			tslot_q <= tidx_s1;
		end
		if (tvld_s1 && !tvalid_q[tidx_s1] && !tfree_q) begin
			tfree_idx_q <= tidx_s1;
		end
	end

	assign sts.dup   = dup_q;
	assign sts.efree = efree_q;
	assign sts.tok   = tmatch_q || tfree_q;

	// build the result beat
	always_comb begin
		res         = '0;
		res.answer  = ans_q;
		res.removed = rem_q;
		if (req_q.op == prt_pkg::OP_CREATE) begin
			if (dup_q) begin
				res.status   = prt_pkg::ST_DUP;
				res.rid      = dup_rec_q.rid;
				res.mac      = dup_rec_q.mac;
				res.kind     = dup_rec_q.kind;
				res.served   = dup_rec_q.served;
				res.consumer = dup_rec_q.consumer;
			end else if (efree_q && (tmatch_q || tfree_q)) begin
				res.status   = prt_pkg::ST_OK;
				res.rid      = req_q.rid;
				res.mac      = req_q.mac;
				res.kind     = req_q.kind;
				res.served   = req_q.served;
				res.consumer = req_q.consumer;
			end else begin
				res.status = prt_pkg::ST_FULL;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = {{(prt_pkg::OUT_BITS - $bits(prt_pkg::res_t)){1'b0}}, out_q};
	assign sts.out_busy = out_valid_q && !out_ready;

`ifndef SYNTHESIS
	a_one_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(esweep_q && tsweep_q))
		else $error("entry and deadline sweeps overlap");
	a_write_slots: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (efree_q && (tmatch_q || tfree_q) && !dup_q))
		else $error("insert without free slots");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(out_valid_q && !out_ready))
		else $error("result register overwritten");
`endif

endmodule

>>> sv/pending_request_table_core.sv
`timescale 1ns / 1ps
// Accept to result: create sweeps entries, then deadlines, then writes; a full deadline store
// skips the write, a duplicate or full entry store the deadline sweep. Tick, remove: deadlines,
// then entries; queries, set served: entries; unused code: no sweep. Output stalls delay results.
// Throughput: one request at a time, paced by the entry and deadline sweeps (one word a cycle);
// a finished result waits in the output register while the next request is taken.
// Reset clears all valid bits and the tick counter at once. Depends on prt_pkg, prt_ctrl, prt_dp.
module pending_request_table_core #(
	parameter int unsigned ENTRIES = prt_pkg::ENTRIES_DEF,
	parameter int unsigned KEYS    = prt_pkg::KEYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// req_type, key_id, requester_id, requester_mac, lifetime, entry_kind, nonce,
	// served_in, consumer_in
	input  logic [prt_pkg::IN_BITS-1:0]   s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status, answer, out_requester_id, out_requester_mac, out_kind, out_served,
	// out_consumer, removed_count
	output logic [prt_pkg::OUT_BITS-1:0]  m_axis_tdata
);

	prt_pkg::cmd_t cmd;
	prt_pkg::sts_t sts;
	logic          in_fire;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	prt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_op    (s_axis_tdata[2:0]),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	prt_dp #(
		.ENTRIES (ENTRIES),
		.KEYS    (KEYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
